// ===== hdl/bole_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the bounded ordered list engine.
// No dependencies.
package bole_pkg;

  localparam int unsigned DEPTH_DEFAULT = 16;
  localparam int unsigned OPCODE_W      = 3;
  localparam int unsigned VALUE_W       = 32;
  localparam int unsigned POS_W         = 5;
  localparam int unsigned STATUS_W      = 3;
  localparam int unsigned FIDX_W        = 4;
  localparam int unsigned COUNT_W       = 5;

  typedef enum logic [OPCODE_W-1:0] {
    OP_INS_HEAD = 3'd0,
    OP_INS_TAIL = 3'd1,
    OP_INS_POS  = 3'd2,
    OP_DEL_HEAD = 3'd3,
    OP_DEL_TAIL = 3'd4,
    OP_DEL_POS  = 3'd5,
    OP_SEARCH   = 3'd6
  } opcode_t;

  typedef enum logic [STATUS_W-1:0] {
    STS_OK       = 3'd0,
    STS_EMPTY    = 3'd1,
    STS_BADPOS   = 3'd2,
    STS_FULL     = 3'd3,
    STS_NOTFOUND = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_INSERT,
    S_DELETE,
    S_SEARCH
  } state_t;

endpackage

// ===== hdl/bole_ram.sv =====
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module bole_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/bounded_ordered_list_engine_top.sv =====
`timescale 1ns / 1ps
// Bounded ordered list engine: a list of up to DEPTH signed 32-bit values kept in list
// order in one RAM (head at address 0); commands insert, delete or search, one result each.
// A command is taken when start is high and busy is low. Commands that fail a check
// (empty list, bad position, full list, search on an empty list) and the unused opcode
// do not raise busy; their result appears in the next cycle. An insert at index p below
// count first moves the entries from the tail down to p one place up, then writes the value;
// a delete at p below count-1 moves the entries after p one place down; an append or a
// delete of the last entry moves none. A search reads entries from the head until the first
// match or the tail, and the result strobe follows in the next cycle.
// Busy time is set by the RAM's single read port: entries are moved or compared one per
// cycle. done is high for exactly one cycle and cannot be held off; results must be taken
// when shown. Depends on bole_pkg and bole_ram.
module bounded_ordered_list_engine_top #(
  parameter int unsigned DEPTH = bole_pkg::DEPTH_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic [bole_pkg::OPCODE_W-1:0]       opcode,
  input  logic signed [bole_pkg::VALUE_W-1:0] value,
  input  logic [bole_pkg::POS_W-1:0]          position,
  output logic                                done,
  output logic [bole_pkg::STATUS_W-1:0]       status,
  output logic [bole_pkg::FIDX_W-1:0]         found_index,
  output logic [bole_pkg::COUNT_W-1:0]        entry_count
);
  import bole_pkg::*;

  localparam int unsigned AW   = $clog2(DEPTH);
  localparam int unsigned CW   = $clog2(DEPTH + 1);
  localparam int unsigned CMPW = (CW > POS_W) ? CW : POS_W;

  state_t                    state, state_next;
  logic [CW-1:0]             count, count_next;
  logic [AW-1:0]             cur, cur_next;
  logic [AW-1:0]             tgt, tgt_next;
  logic [AW-1:0]             waddr, waddr_next;
  logic                      rd_on, rd_on_next;
  logic                      pend, pend_next;
  logic [VALUE_W-1:0]        key, key_next;
  logic                      res_done, res_done_next;
  status_t                   res_status, res_status_next;
  logic [FIDX_W-1:0]         res_fidx, res_fidx_next;
  logic [COUNT_W-1:0]        res_count, res_count_next;

  logic                      ram_we;
  logic [AW-1:0]             ram_waddr, ram_raddr;
  logic [VALUE_W-1:0]        ram_wdata, ram_rdata;

  opcode_t                   op;
  logic [CMPW-1:0]           pos_w, cnt_w;
  logic [CW-1:0]             cnt_m1;
  logic                      is_full, is_empty, ins_bad, del_bad;
  logic [AW-1:0]             ins_p, del_p, last;
  logic                      ins_fin, del_fin, hit, miss;

  bole_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // command checks
  always_comb begin
    op       = opcode_t'(opcode);
    pos_w    = CMPW'(position);
    cnt_w    = CMPW'(count);
    cnt_m1   = count - CW'(1);
    last     = AW'(cnt_m1);
    is_full  = (count == CW'(DEPTH));
    is_empty = (count == '0);
    ins_bad  = (op == OP_INS_POS) && (pos_w > cnt_w);
    del_bad  = (op == OP_DEL_POS) && (pos_w >= cnt_w);
    ins_p    = (op == OP_INS_HEAD) ? '0 : (op == OP_INS_TAIL) ? AW'(count) : AW'(position);
    del_p    = (op == OP_DEL_HEAD) ? '0 : (op == OP_DEL_TAIL) ? last : AW'(position);
  end

  assign ins_fin = (state == S_INSERT) && !rd_on && !pend;
  assign del_fin = (state == S_DELETE) && !rd_on && !pend;
  assign hit     = (state == S_SEARCH) && pend && (ram_rdata == key);
  assign miss    = (state == S_SEARCH) && pend && !rd_on && (ram_rdata != key);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          unique case (op)
            OP_INS_HEAD, OP_INS_TAIL, OP_INS_POS: begin
              if (!ins_bad && !is_full) state_next = S_INSERT;
            end
            OP_DEL_HEAD, OP_DEL_TAIL, OP_DEL_POS: begin
              if (!is_empty && !del_bad) state_next = S_DELETE;
            end
            OP_SEARCH: begin
              if (!is_empty) state_next = S_SEARCH;
            end
            default: ;
          endcase
        end
      end
      S_INSERT: if (ins_fin) state_next = S_IDLE;
      S_DELETE: if (del_fin) state_next = S_IDLE;
      S_SEARCH: if (hit || miss) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // datapath and results
  always_comb begin
    count_next      = count;
    cur_next        = cur;
    tgt_next        = tgt;
    waddr_next      = waddr;
    rd_on_next      = rd_on;
    pend_next       = pend;
    key_next        = key;
    res_done_next   = 1'b0;
    res_status_next = res_status;
    res_fidx_next   = res_fidx;
    res_count_next  = res_count;
    ram_we          = 1'b0;
    ram_waddr       = waddr;
    ram_wdata       = ram_rdata;
    ram_raddr       = cur;

    unique case (state)
      S_IDLE: begin
        if (start) begin
          key_next       = value;
          pend_next      = 1'b0;
          rd_on_next     = 1'b0;
          res_fidx_next  = '0;
          res_count_next = COUNT_W'(count);
          res_status_next = STS_OK;
          unique case (op)
            OP_INS_HEAD, OP_INS_TAIL, OP_INS_POS: begin
              if (ins_bad) begin
                res_done_next   = 1'b1;
                res_status_next = STS_BADPOS;
              end else if (is_full) begin
                res_done_next   = 1'b1;
                res_status_next = STS_FULL;
              end else begin
                tgt_next   = ins_p;
                cur_next   = last;
                rd_on_next = (ins_p != AW'(count));
              end
            end
            OP_DEL_HEAD, OP_DEL_TAIL, OP_DEL_POS: begin
              if (is_empty) begin
                res_done_next   = 1'b1;
                res_status_next = STS_EMPTY;
              end else if (del_bad) begin
                res_done_next   = 1'b1;
                res_status_next = STS_BADPOS;
              end else begin
                tgt_next   = del_p;
                cur_next   = del_p + AW'(1);
                rd_on_next = (del_p != last);
              end
            end
            OP_SEARCH: begin
              if (is_empty) begin
                res_done_next   = 1'b1;
                res_status_next = STS_NOTFOUND;
              end else begin
                cur_next   = '0;
                rd_on_next = 1'b1;
              end
            end
            default: res_done_next = 1'b1;
          endcase
        end
      end

      // shift up, from the tail down to the target
      S_INSERT: begin
        ram_we    = pend;
        pend_next = rd_on;
        if (rd_on) begin
          waddr_next = cur + AW'(1);
          if (cur == tgt) rd_on_next = 1'b0;
          else cur_next = cur - AW'(1);
        end
        if (ins_fin) begin
          ram_we          = 1'b1;
          ram_waddr       = tgt;
          ram_wdata       = key;
          count_next      = count + CW'(1);
          res_done_next   = 1'b1;
          res_status_next = STS_OK;
          res_count_next  = COUNT_W'(count + CW'(1));
        end
      end

      // shift down, from just after the target to the tail
      S_DELETE: begin
        ram_we    = pend;
        pend_next = rd_on;
        if (rd_on) begin
          waddr_next = cur - AW'(1);
          if (cur == last) rd_on_next = 1'b0;
          else cur_next = cur + AW'(1);
        end
        if (del_fin) begin
          count_next      = cnt_m1;
          res_done_next   = 1'b1;
          res_status_next = STS_OK;
          res_count_next  = COUNT_W'(cnt_m1);
        end
      end

      S_SEARCH: begin
        pend_next  = rd_on;
        waddr_next = cur;
        if (rd_on) begin
          if (cur == last) rd_on_next = 1'b0;
          else cur_next = cur + AW'(1);
        end
        if (hit) begin
          rd_on_next      = 1'b0;
          pend_next       = 1'b0;
          res_done_next   = 1'b1;
          res_status_next = STS_OK;
          res_fidx_next   = FIDX_W'(waddr);
        end else if (miss) begin
          pend_next       = 1'b0;
          res_done_next   = 1'b1;
          res_status_next = STS_NOTFOUND;
          res_fidx_next   = '0;
        end
      end

      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      rd_on    <= 1'b0;
      pend     <= 1'b0;
      res_done <= 1'b0;
    end else begin
      state    <= state_next;
      count    <= count_next;
      rd_on    <= rd_on_next;
      pend     <= pend_next;
      res_done <= res_done_next;
    end
  end

  always_ff @(posedge clk) begin
    cur        <= cur_next;
    tgt        <= tgt_next;
    waddr      <= waddr_next;
    key        <= key_next;
    res_status <= res_status_next;
    res_fidx   <= res_fidx_next;
    res_count  <= res_count_next;
  end

  assign busy        = (state != S_IDLE);
  assign done        = res_done;
  assign status      = res_status;
  assign found_index = res_fidx;
  assign entry_count = res_count;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("entry count above capacity");

  a_idle_clean: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> !rd_on && !pend)
    else $error("read pipeline active while idle");

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    (ram_we && rd_on) |-> ram_waddr != ram_raddr)
    else $error("shift writes the entry being read");

  a_done_cause: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy) || $past(start))
    else $error("result strobe without a transaction");

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// Testbench for bounded_ordered_list_engine_top: directed and random command transactions,
// each result checked against a behavioural copy of the list held in a scoreboard class.
// Depends on bole_pkg and the engine RTL.
module tb;
  import bole_pkg::*;

  localparam int unsigned LIST_DEPTH  = DEPTH_DEFAULT;
  localparam int unsigned N_RANDOM    = 1420;
  localparam int unsigned QUIET_TAIL  = 200;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam logic [OPCODE_W-1:0] OP_UNUSED = 3'd7;

  typedef struct packed {
    status_t             status;
    logic [FIDX_W-1:0]   fidx;
    logic [COUNT_W-1:0]  count;
  } outcome_t;

  class list_checker;
    logic [VALUE_W-1:0] slots [LIST_DEPTH];
    int unsigned        fill = 0;
    outcome_t           awaited [$];
    int unsigned        errors = 0;

    task flag(input string msg);
      $display("%0t mismatch: %s", $time, msg);
      errors++;
    endtask

    // apply one accepted command to the list and queue the outcome it must give
    function void note(input logic [OPCODE_W-1:0] op, input logic [VALUE_W-1:0] val,
                       input logic [POS_W-1:0] pos);
      status_t           st;
      logic [FIDX_W-1:0] fidx;
      int unsigned       p;
      st   = STS_OK;
      fidx = '0;
      case (op)
        OP_INS_HEAD, OP_INS_TAIL, OP_INS_POS: begin
          if (op == OP_INS_POS && pos > fill) st = STS_BADPOS;
          else if (fill >= LIST_DEPTH) st = STS_FULL;
          else begin
            p = (op == OP_INS_HEAD) ? 0 : ((op == OP_INS_TAIL) ? fill : pos);
            for (int unsigned i = fill; i > p; i--) slots[i] = slots[i-1];
            slots[p] = val;
            fill++;
          end
        end
        OP_DEL_HEAD, OP_DEL_TAIL, OP_DEL_POS: begin
          if (fill == 0) st = STS_EMPTY;
          else if (op == OP_DEL_POS && pos >= fill) st = STS_BADPOS;
          else begin
            p = (op == OP_DEL_HEAD) ? 0 : ((op == OP_DEL_TAIL) ? fill - 1 : pos);
            for (int unsigned i = p; i + 1 < fill; i++) slots[i] = slots[i+1];
            fill--;
          end
        end
        OP_SEARCH: begin
          st = STS_NOTFOUND;
          for (int unsigned i = 0; i < fill; i++) begin
            if (slots[i] == val) begin
              st   = STS_OK;
              fidx = i[FIDX_W-1:0];
              break;
            end
          end
        end
        default: ;
      endcase
      awaited.push_back('{st, fidx, fill[COUNT_W-1:0]});
    endfunction

    task check(input logic [STATUS_W-1:0] st, input logic [FIDX_W-1:0] fi,
               input logic [COUNT_W-1:0] ec);
      outcome_t got;
      outcome_t want;
      got = {st, fi, ec};
      if (awaited.size() == 0) begin
        flag($sformatf("unexpected result status %0d index %0d count %0d", st, fi, ec));
        return;
      end
      want = awaited.pop_front();
      if (got !== want)
        flag($sformatf("status %0d exp %0d, index %0d exp %0d, count %0d exp %0d",
                       st, want.status, fi, want.fidx, ec, want.count));
    endtask
  endclass

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       start = 1'b0;
  logic                       busy;
  logic [OPCODE_W-1:0]        opcode = '0;
  logic signed [VALUE_W-1:0]  value = '0;
  logic [POS_W-1:0]           position = '0;
  logic                       done;
  logic [STATUS_W-1:0]        status;
  logic [FIDX_W-1:0]          found_index;
  logic [COUNT_W-1:0]         entry_count;

  list_checker sb = new;
  int unsigned cycles = 0;

  bounded_ordered_list_engine_top dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .opcode(opcode), .value(value), .position(position),
    .done(done), .status(status), .found_index(found_index), .entry_count(entry_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && done) sb.check(status, found_index, entry_count);
  end

  // start stays high on return so back-to-back transactions need no extra edge
  task automatic issue(input logic [OPCODE_W-1:0] op, input logic [VALUE_W-1:0] val,
                       input logic [POS_W-1:0] pos);
    start    <= 1'b1;
    opcode   <= op;
    value    <= val;
    position <= pos;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note(op, val, pos);
  endtask

  task automatic pause(input int unsigned n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  initial begin
    int unsigned         c;
    int unsigned         r;
    bit                  grow;
    bit                  quiet;
    logic [OPCODE_W-1:0] op;
    logic [VALUE_W-1:0]  val;
    logic [POS_W-1:0]    pos;

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // empty list
    issue(OP_SEARCH, 32'd0, 5'd0);
    issue(OP_DEL_HEAD, 32'd0, 5'd0);
    issue(OP_DEL_TAIL, 32'd0, 5'd0);
    issue(OP_DEL_POS, 32'd0, 5'd0);
    issue(OP_UNUSED, 32'hFFFF_FFFF, 5'd31);
    issue(OP_INS_POS, 32'd1, 5'd1);
    // build a short list with extreme values
    issue(OP_INS_POS, 32'h8000_0000, 5'd0);
    issue(OP_INS_TAIL, 32'h7FFF_FFFF, 5'd0);
    issue(OP_INS_HEAD, 32'hFFFF_FFFF, 5'd0);
    issue(OP_INS_POS, 32'hAAAA_AAAA, 5'd3);
    issue(OP_INS_POS, 32'h5555_5555, 5'd2);
    issue(OP_SEARCH, 32'h7FFF_FFFF, 5'd0);
    issue(OP_SEARCH, 32'h8000_0000, 5'd0);
    issue(OP_SEARCH, 32'd12345, 5'd0);
    issue(OP_DEL_POS, 32'd0, 5'd5);
    // fill to capacity, then full and bad-position priority
    for (c = 0; c < LIST_DEPTH - 5; c++) issue(OP_INS_TAIL, 32'd100 + c, 5'd0);
    issue(OP_INS_HEAD, 32'd7, 5'd0);
    issue(OP_INS_TAIL, 32'd7, 5'd0);
    issue(OP_INS_POS, 32'd7, 5'd16);
    issue(OP_INS_POS, 32'd7, 5'd17);
    issue(OP_SEARCH, 32'd100 + LIST_DEPTH - 6, 5'd0);
    issue(OP_DEL_POS, 32'd0, 5'd15);
    issue(OP_DEL_POS, 32'd0, 5'd3);
    issue(OP_DEL_HEAD, 32'd0, 5'd0);
    issue(OP_DEL_TAIL, 32'd0, 5'd0);

    grow  = 1'b1;
    quiet = 1'b0;
    for (int unsigned n = 0; n < N_RANDOM; n++) begin
      c = sb.fill;
      if (c >= LIST_DEPTH) grow = 1'b0;
      else if (c == 0) grow = 1'b1;
      else if ($urandom_range(0, 49) == 0) grow = !grow;

      r = $urandom_range(0, 99);
      if (r < 3) op = OP_UNUSED;
      else if (r < 20) op = OP_SEARCH;
      else if (grow ? (r < 70) : (r < 45)) op = OPCODE_W'($urandom_range(0, 2));
      else op = OPCODE_W'($urandom_range(3, 5));

      r = $urandom_range(0, 9);
      if (r < 4) val = VALUE_W'(int'($urandom_range(0, 6)) - 3);
      else if (r == 4) begin
        case ($urandom_range(0, 3))
          0:       val = 32'h8000_0000;
          1:       val = 32'h7FFF_FFFF;
          2:       val = 32'h0000_0000;
          default: val = 32'hFFFF_FFFF;
        endcase
      end else val = $urandom;
      if (op == OP_SEARCH && c > 0 && $urandom_range(0, 2) != 0)
        val = sb.slots[$urandom_range(0, c - 1)];

      if ($urandom_range(0, 9) == 0 || (op != OP_INS_POS && op != OP_DEL_POS))
        pos = POS_W'($urandom_range(0, 31));
      else if (op == OP_DEL_POS) pos = POS_W'((c > 0) ? $urandom_range(0, c - 1) : 0);
      else pos = POS_W'($urandom_range(0, c));

      issue(op, val, pos);

      if (n % 150 == 0) quiet = ($urandom_range(0, 3) == 0);
      if (n < N_RANDOM - QUIET_TAIL && !quiet && $urandom_range(0, 4) == 0)
        pause($urandom_range(1, 14));
    end
    start <= 1'b0;

    while (sb.awaited.size() != 0) @(posedge clk);
    repeat (LIST_DEPTH + 8) @(posedge clk);
    if (sb.errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
